@@ hdl/zmr_pkg.sv @@
// ----------------------------------------------------------------------------
// zmr_pkg
// Shared sizes, types and register codes for the zigzag matrix reorder block.
// ----------------------------------------------------------------------------
package zmr_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int AW       = $clog2(DEPTH);
  localparam int DW       = 32;
  localparam int RW       = $clog2(MAX_ROWS);
  localparam int CW       = $clog2(MAX_COLS);
  localparam int SZW      = 4;
  localparam int CNTW     = 7;

  typedef logic [AW-1:0]        addr_t;
  typedef logic signed [DW-1:0] data_t;

  // Matrix size, each dimension minus one
  typedef struct packed {
    logic [RW-1:0] rows_m1;
    logic [CW-1:0] cols_m1;
  } dim_t;

  // Read request from the scan sequencer
  typedef struct packed {
    logic  vld;
    addr_t addr;
    logic  last;
  } rd_req_t;

  // One result word
  typedef struct packed {
    data_t data;
    logic  last;
  } out_word_t;

  typedef enum logic [0:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_idx_t;

  // Clamp a size register to 1..lim and return it minus one
  function automatic logic [2:0] size_m1(input logic [SZW-1:0] v,
                                         input logic [SZW-1:0] lim);
    logic [SZW-1:0] t;
    t = v;
    if (v == '0) begin
      t = SZW'(1);
    end else if (v > lim) begin
      t = lim;
    end
    t = t - SZW'(1);
    return t[2:0];
  endfunction

endpackage

@@ hdl/zigzag_matrix_reorder_core.sv @@
// ----------------------------------------------------------------------------
// zigzag_matrix_reorder_core
// Loads a matrix in row-major order and emits it in zigzag diagonal order.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | sink      | in_valid / in_stall | in_element_in
//  out     | source    | out_valid/out_stall | out_element_out, out_last_of_scan
//  cfg     | sink      | cfg_we              | cfg_index, cfg_wdata
//
//  Load accepts a word while in_stall is low; each word is written straight
//  into the element memory. The word that completes the matrix starts the
//  scan. The scan issues one memory read per cycle while the output queue
//  has room (single read port, registered read data). in_stall stays high
//  while reads remain.
//  Reset is synchronous, active low: sizes go to 8 by 8, the load count
//  clears. The memory is not cleared; no clearing pass runs.
//  out_stall throttles reads through the two-word output queue.
//
module zigzag_matrix_reorder_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_element_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_element_out,
  output logic                 out_last_of_scan,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [3:0]           cfg_wdata
);
  import zmr_pkg::*;

  logic [SZW-1:0]  row_cnt_r, col_cnt_r;
  logic [CNTW-1:0] load_cnt_r, load_cnt_nxt;
  logic [CNTW-1:0] total, ld_base, ld_inc;
  dim_t            dim;
  logic            in_acc, load_done, issue, pop;
  logic            rd_vld_r, rd_last_r;
  logic [1:0]      q_count, q_after_pop;
  rd_req_t         req;
  data_t           rd_data;
  out_word_t       head_word, push_word;

  // Configuration registers; any write discards a partly loaded matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= SZW'(MAX_ROWS);
      col_cnt_r <= SZW'(MAX_COLS);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROW_COUNT: row_cnt_r <= cfg_wdata;
        CFG_COL_COUNT: col_cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign dim.rows_m1 = size_m1(row_cnt_r, SZW'(MAX_ROWS));
  assign dim.cols_m1 = size_m1(col_cnt_r, SZW'(MAX_COLS));
  assign total = (CNTW'(dim.rows_m1) + CNTW'(1)) * (CNTW'(dim.cols_m1) + CNTW'(1));

  // Load side: hold input while the scan still has reads to issue
  assign in_stall  = req.vld;
  assign in_acc    = in_valid && !in_stall;
  assign ld_base   = (load_cnt_r >= total) ? '0 : load_cnt_r;
  assign ld_inc    = ld_base + CNTW'(1);
  assign load_done = in_acc && (ld_inc == total);

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (cfg_we) begin
      load_cnt_nxt = '0;
    end else if (in_acc) begin
      load_cnt_nxt = load_done ? '0 : ld_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
    end
  end

  // Issue a read only when the queue will have room for its read data
  assign pop         = out_valid && !out_stall;
  assign q_after_pop = q_count - 2'(pop);
  assign issue       = req.vld && ((q_after_pop + 2'(rd_vld_r)) < 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last_r <= req.last;
    end
  end

  zmr_store u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (ld_base[AW-1:0]),
    .wdata (in_element_in),
    .re    (issue),
    .raddr (req.addr),
    .rdata (rd_data)
  );

  zmr_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (load_done),
    .dim   (dim),
    .adv   (issue),
    .req   (req)
  );

  assign push_word.data = rd_data;
  assign push_word.last = rd_last_r;

  zmr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rd_vld_r),
    .push_word (push_word),
    .pop       (pop),
    .head_vld  (out_valid),
    .head_word (head_word),
    .count     (q_count)
  );

  assign out_element_out  = head_word.data;
  assign out_last_of_scan = head_word.last;

endmodule

@@ hdl/zmr_store.sv @@
// ----------------------------------------------------------------------------
// zmr_store
// Element memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module zmr_store (
  input  logic          clk,
  input  logic          we,
  input  zmr_pkg::addr_t waddr,
  input  zmr_pkg::data_t wdata,
  input  logic          re,
  input  zmr_pkg::addr_t raddr,
  output zmr_pkg::data_t rdata
);
  import zmr_pkg::*;

  data_t mem [DEPTH];
  data_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/zmr_scan.sv @@
// ----------------------------------------------------------------------------
// zmr_scan
// Zigzag sequencer: walks the diagonals and issues one read address per step.
// ----------------------------------------------------------------------------
module zmr_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  zmr_pkg::dim_t    dim,
  input  logic             adv,
  output zmr_pkg::rd_req_t req
);
  import zmr_pkg::*;

  logic          active_r, active_nxt;
  logic          up_r, up_nxt;
  logic [RW-1:0] r_r, r_nxt, tr_r, tr_nxt, br_r, br_nxt;
  logic [CW-1:0] c_r, c_nxt, tc_r, tc_nxt, bc_r, bc_nxt;
  logic          at_last, end_diag;
  addr_t         cols_ext;

  assign cols_ext = AW'(dim.cols_m1) + AW'(1);
  assign at_last  = (r_r == dim.rows_m1) && (c_r == dim.cols_m1);
  assign end_diag = up_r ? (r_r == tr_r) : (r_r == br_r);

  assign req.vld  = active_r;
  assign req.addr = AW'(r_r) * cols_ext + AW'(c_r);
  assign req.last = at_last;

  always_comb begin
    active_nxt = active_r;
    up_nxt     = up_r;
    r_nxt      = r_r;
    c_nxt      = c_r;
    tr_nxt     = tr_r;
    tc_nxt     = tc_r;
    br_nxt     = br_r;
    bc_nxt     = bc_r;
    if (start) begin
      active_nxt = 1'b1;
      up_nxt     = 1'b0;
      r_nxt      = '0;
      c_nxt      = '0;
      tr_nxt     = '0;
      tc_nxt     = '0;
      br_nxt     = '0;
      bc_nxt     = '0;
    end else if (active_r && adv) begin
      if (at_last) begin
        active_nxt = 1'b0;
      end else if (end_diag) begin
        // upper end runs along the top row, then down the right column
        if (tc_r != dim.cols_m1) begin
          tc_nxt = tc_r + CW'(1);
        end else begin
          tr_nxt = tr_r + RW'(1);
        end
        // lower end runs down the left column, then along the bottom row
        if (br_r != dim.rows_m1) begin
          br_nxt = br_r + RW'(1);
        end else begin
          bc_nxt = bc_r + CW'(1);
        end
        up_nxt = !up_r;
        if (!up_r) begin
          r_nxt = br_nxt;
          c_nxt = bc_nxt;
        end else begin
          r_nxt = tr_nxt;
          c_nxt = tc_nxt;
        end
      end else if (up_r) begin
        r_nxt = r_r - RW'(1);
        c_nxt = c_r + CW'(1);
      end else begin
        r_nxt = r_r + RW'(1);
        c_nxt = c_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    up_r <= up_nxt;
    r_r  <= r_nxt;
    c_r  <= c_nxt;
    tr_r <= tr_nxt;
    tc_r <= tc_nxt;
    br_r <= br_nxt;
    bc_r <= bc_nxt;
  end

endmodule

@@ hdl/zmr_outq.sv @@
// ----------------------------------------------------------------------------
// zmr_outq
// Two-word output queue between the memory read register and the result port.
// ----------------------------------------------------------------------------
module zmr_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  zmr_pkg::out_word_t push_word,
  input  logic               pop,
  output logic               head_vld,
  output zmr_pkg::out_word_t head_word,
  output logic [1:0]         count
);
  import zmr_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  out_word_t  s0_r, s0_nxt, s1_r, s1_nxt;

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    s0_nxt  = s0_r;
    s1_nxt  = s1_r;
    if (pop) begin
      s0_nxt = s1_r;
    end
    if (push) begin
      if ((cnt_r - 2'(pop)) == 2'd0) begin
        s0_nxt = push_word;
      end else begin
        s1_nxt = push_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

  assign head_vld  = (cnt_r != 2'd0);
  assign head_word = s0_r;
  assign count     = cnt_r;

endmodule

@@ hdl/zmr_checker.sv @@
// ----------------------------------------------------------------------------
// zmr_checker
// Port-level checks for the zigzag matrix reorder block, bound to the top.
// ----------------------------------------------------------------------------
module zmr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic signed [31:0]  out_element_out,
  input logic                out_last_of_scan
);

  // Reset empties the result side and opens the load side
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  // The load side closes only on an accepted word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("in_stall rose without an accepted word");

  // A shown result word carries no unknown bits
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_element_out, out_last_of_scan}))
    else $error("result word has unknown bits");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_element_out)
                               && $stable(out_last_of_scan))
    else $error("stalled result changed");

endmodule

bind zigzag_matrix_reorder_core zmr_checker u_zmr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_element_out  (out_element_out),
  .out_last_of_scan (out_last_of_scan)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zigzag matrix reorder core. Matrices go in row
// by row and come back in zigzag diagonal order. A local predictor follows
// every accepted word and every size write and queues the scan it expects.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import zmr_pkg::*;

  // Generous cycle budget for the whole run.
  localparam int unsigned CYCLE_LIMIT = 300000;
  // Cycles to let pass after the last expected word before touching config.
  localparam int unsigned SETTLE_CYCLES = 12;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  data_t      in_element_in = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  data_t      out_element_out;
  logic       out_last_of_scan;
  logic       cfg_we = 1'b0;
  cfg_idx_t   cfg_index = CFG_ROW_COUNT;
  logic [3:0] cfg_wdata = '0;

  // Predictor state: size registers, element copy, words loaded so far.
  logic [3:0]  row_reg = 4'd8;
  logic [3:0]  col_reg = 4'd8;
  data_t       element_copy [DEPTH];
  logic [6:0]  words_loaded = '0;
  out_word_t   pending_scan_q [$];

  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned stall_left = 0;

  zigzag_matrix_reorder_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_in    (in_element_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_element_out  (out_element_out),
    .out_last_of_scan (out_last_of_scan),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Size register as the block uses it: zero reads as one, large values clip.
  function automatic int dim_in_use(input logic [3:0] v, input int lim);
    if (v == 4'd0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic int cells_in_use();
    return dim_in_use(row_reg, MAX_ROWS) * dim_in_use(col_reg, MAX_COLS);
  endfunction

  // Queue one cell of the scan; the final cell of the matrix carries last.
  function automatic void queue_cell(input int r, input int c, input int cols,
                                     inout int n, input int total);
    out_word_t w;
    w.data = element_copy[r * cols + c];
    w.last = (n == total - 1);
    pending_scan_q.push_back(w);
    n++;
  endfunction

  // Walk the diagonals. The upper end runs along the top row then down the
  // right column; the lower end runs down the left column then along the
  // bottom row. Odd diagonals climb, even ones descend.
  function automatic void expect_zigzag();
    int rows, cols, total, n;
    int hi_r, hi_c, lo_r, lo_c, r, c;
    bit climbing;
    rows = dim_in_use(row_reg, MAX_ROWS);
    cols = dim_in_use(col_reg, MAX_COLS);
    total = rows * cols;
    hi_r = 0; hi_c = 0; lo_r = 0; lo_c = 0;
    climbing = 1'b0;
    n = 0;
    while (hi_r < rows) begin
      if (climbing) begin
        r = lo_r; c = lo_c;
        while (r >= hi_r) begin
          queue_cell(r, c, cols, n, total);
          r--; c++;
        end
      end else begin
        r = hi_r; c = hi_c;
        while (r <= lo_r) begin
          queue_cell(r, c, cols, n, total);
          r++; c--;
        end
      end
      if (hi_c != cols - 1) hi_c++; else hi_r++;
      if (lo_r != rows - 1) lo_r++; else lo_c++;
      climbing = !climbing;
    end
  endfunction

  // Store one accepted word; the word that fills the matrix releases a scan.
  function automatic void load_element(input data_t w);
    int total;
    total = cells_in_use();
    if (int'(words_loaded) >= total) words_loaded = '0;
    element_copy[words_loaded[AW-1:0]] = w;
    words_loaded = words_loaded + 7'd1;
    if (int'(words_loaded) >= total) begin
      words_loaded = '0;
      expect_zigzag();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, and the word checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scan_q.size() == 0) begin
        $error("unexpected word: element_out %0d, last_of_scan %0b",
               out_element_out, out_last_of_scan);
        mismatch_count++;
      end else begin
        want = pending_scan_q.pop_front();
        if (out_element_out !== want.data) begin
          $error("element_out: expected %0d, actual %0d", want.data, out_element_out);
          mismatch_count++;
        end
        if (out_last_of_scan !== want.last) begin
          $error("last_of_scan: expected %0b, actual %0b", want.last, out_last_of_scan);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Send one word: maybe drop valid for a short burst first, then hold the
  // word until the block takes it. Valid stays high on return so that
  // back-to-back words keep streaming.
  task automatic send_word(input data_t w);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_in <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    load_element(w);
    words_sent++;
  endtask

  // Mostly full-range random words, with the corner values mixed in.
  function automatic data_t pick_element();
    case ($urandom_range(0, 11))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_words(input int unsigned count);
    repeat (count) send_word(pick_element());
  endtask

  // Drop valid, wait until every expected word is back, then let the block
  // settle so a configuration write finds it idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_scan_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write, after which cfg_we drops again. Any write discards a
  // partly loaded matrix.
  task automatic write_size(input cfg_idx_t idx, input logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    if (idx == CFG_ROW_COUNT) row_reg = v;
    else col_reg = v;
    words_loaded = '0;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(input logic [3:0] rows, input logic [3:0] cols);
    write_size(CFG_ROW_COUNT, rows);
    write_size(CFG_COL_COUNT, cols);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset leaves an 8 by 8 matrix in force.
  task automatic test_reset_size();
    send_words(cells_in_use());
    drain();
  endtask

  // 1 by 1: every word is a whole scan, so the corner values each come back
  // alone with last set.
  task automatic test_single_cell();
    set_shape(4'd1, 4'd1);
    send_word(32'sh7FFF_FFFF);
    send_word(32'sh8000_0000);
    send_word('0);
    send_word('1);
    drain();
  endtask

  // A size of zero counts as one.
  task automatic test_zero_size();
    set_shape(4'd0, 4'd0);
    send_word(32'shAAAA_AAAA);
    send_word(32'sh5555_5555);
    drain();
  endtask

  // Single column and single row: the scan is plain order.
  task automatic test_thin_shapes();
    set_shape(4'd3, 4'd1);
    send_words(3);
    drain();
    set_shape(4'd1, 4'd3);
    send_words(3);
    drain();
  endtask

  // Load half a matrix, then change a size: the partial load is dropped and
  // the next matrix starts from its first word.
  task automatic test_resize_mid_matrix();
    set_shape(4'd2, 4'd3);
    send_words(3);
    drain();
    write_size(CFG_COL_COUNT, 4'd2);
    send_words(4);
    drain();
  endtask

  // Sizes above the maximum clip to 8 by 8.
  task automatic test_oversize();
    set_shape(4'd15, 4'd9);
    send_words(cells_in_use());
    drain();
  endtask

  function automatic logic [3:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 4'd0;
      1:       return 4'($urandom_range(9, 15));
      2:       return 4'd8;
      default: return 4'($urandom_range(1, 6));
    endcase
  endfunction

  // Random shapes, a few whole matrices each, now and then a broken partial
  // load before the next size change. Idling switches on and off per phase.
  task automatic test_random_shapes();
    int total;
    while (words_sent < 440) begin
      set_shape(pick_size(), pick_size());
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      total = cells_in_use();
      repeat ($urandom_range(1, 3)) send_words(total);
      if (total > 1 && $urandom_range(0, 4) == 0) send_words($urandom_range(1, total - 1));
      drain();
    end
  endtask

  // Last stretch: no idling on either side, matrices back to back.
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_shape(4'd3, 4'd5);
    send_words(45);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_single_cell();
    test_zero_size();
    test_thin_shapes();
    test_resize_mid_matrix();
    test_oversize();
    test_random_shapes();
    test_back_to_back();

    if (mismatch_count == 0 && pending_scan_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/zmr_pkg.sv
hdl/zmr_store.sv
hdl/zmr_scan.sv
hdl/zmr_outq.sv
hdl/zigzag_matrix_reorder_core.sv
hdl/zmr_checker.sv
test/tb_top.sv
